// ===== hdl/tlr_pkg.sv =====
// ----------------------------------------------------------------------------
// tlr_pkg
// Shared constants and codes of the triangle and line rasterizer.
// ----------------------------------------------------------------------------
package tlr_pkg;

  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 128;
  localparam int DEF_FRAC_BITS  = 16;

  localparam int COORD_W  = 12;  // vertex coordinate, signed
  localparam int DELTA_W  = 14;  // vertex difference, signed
  localparam int PIX_W    = 14;  // pixel coordinate and counters, signed
  localparam int COLOR_W  = 32;
  localparam int COUNT_W  = 15;
  localparam int KIND_W   = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

  localparam logic [CFG_DATA_W-1:0] SCREEN_RESET = 8'd128;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_LINE    = 2'd0,
    KIND_OUTLINE = 2'd1,
    KIND_FILL    = 2'd2,
    KIND_READ    = 2'd3
  } kind_t;

endpackage

// ===== hdl/tlr_cmd_if.sv =====
// ----------------------------------------------------------------------------
// tlr_cmd_if
// Draw command channel: valid, ready and one command item.
// ----------------------------------------------------------------------------
interface tlr_cmd_if;
  logic                                      valid;
  logic                                      ready;
  logic        [tlr_pkg::KIND_W-1:0]         kind;
  logic signed [tlr_pkg::COORD_W-1:0]        first_x;
  logic signed [tlr_pkg::COORD_W-1:0]        first_y;
  logic signed [tlr_pkg::COORD_W-1:0]        second_x;
  logic signed [tlr_pkg::COORD_W-1:0]        second_y;
  logic signed [tlr_pkg::COORD_W-1:0]        third_x;
  logic signed [tlr_pkg::COORD_W-1:0]        third_y;
  logic        [tlr_pkg::COLOR_W-1:0]        first_colour;
  logic        [tlr_pkg::COLOR_W-1:0]        second_colour;
  logic        [tlr_pkg::COLOR_W-1:0]        third_colour;

  modport source (
    output valid, kind, first_x, first_y, second_x, second_y, third_x, third_y,
           first_colour, second_colour, third_colour,
    input  ready
  );
  modport sink (
    input  valid, kind, first_x, first_y, second_x, second_y, third_x, third_y,
           first_colour, second_colour, third_colour,
    output ready
  );
endinterface

// ===== hdl/tlr_res_if.sv =====
// ----------------------------------------------------------------------------
// tlr_res_if
// Result channel: valid, ready and one result item.
// ----------------------------------------------------------------------------
interface tlr_res_if;
  logic                          valid;
  logic                          ready;
  logic [tlr_pkg::COLOR_W-1:0]   read_colour;
  logic [tlr_pkg::COUNT_W-1:0]   pixels_written;

  modport source (output valid, read_colour, pixels_written, input ready);
  modport sink   (input  valid, read_colour, pixels_written, output ready);
endinterface

// ===== hdl/tlr_ram.sv =====
// ----------------------------------------------------------------------------
// tlr_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/tlr_div.sv =====
// ----------------------------------------------------------------------------
// tlr_div
// Radix-2 restoring divider for fixed-point slopes: (num << FRAC) / den,
// truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tlr_div #(
  parameter int FRAC_BITS = tlr_pkg::DEF_FRAC_BITS,
  parameter int POS_W     = tlr_pkg::DEF_FRAC_BITS + 15
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [tlr_pkg::DELTA_W-1:0]  num,
  input  logic signed [tlr_pkg::DELTA_W-1:0]  den,
  output logic                                done,
  output logic signed [POS_W-1:0]             quot
);

  localparam int MAG_W = tlr_pkg::DELTA_W - 1;
  localparam int DW    = MAG_W + FRAC_BITS;
  localparam int CNT_W = $clog2(DW + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    dvd;
  logic [DW-1:0]    q;
  logic [MAG_W-1:0] rem;
  logic [MAG_W-1:0] den_mag;
  logic             neg;

  logic signed [tlr_pkg::DELTA_W-1:0] num_abs;
  logic signed [tlr_pkg::DELTA_W-1:0] den_abs;
  logic [MAG_W:0]                     rem_sh;
  logic                               fits;
  logic [MAG_W-1:0]                   rem_next;
  logic [DW-1:0]                      q_next;
  logic signed [POS_W-1:0]            q_ext;

  always_comb begin
    num_abs  = num[tlr_pkg::DELTA_W-1] ? -num : num;
    den_abs  = den[tlr_pkg::DELTA_W-1] ? -den : den;
    rem_sh   = {rem, dvd[DW-1]};
    fits     = rem_sh >= {1'b0, den_mag};
    rem_next = fits ? MAG_W'(rem_sh - {1'b0, den_mag}) : rem_sh[MAG_W-1:0];
    q_next   = {q[DW-2:0], fits};
    q_ext    = POS_W'(q_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd     <= {num_abs[MAG_W-1:0], {FRAC_BITS{1'b0}}};
      den_mag <= den_abs[MAG_W-1:0];
      q       <= '0;
      rem     <= '0;
      neg     <= num[tlr_pkg::DELTA_W-1] ^ den[tlr_pkg::DELTA_W-1];
    end else if (busy) begin
      dvd <= {dvd[DW-2:0], 1'b0};
      q   <= q_next;
      rem <= rem_next;
      if (cnt == CNT_W'(DW - 1)) begin
        quot <= neg ? -q_ext : q_ext;
      end
    end
  end

endmodule

// ===== hdl/triangle_and_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// triangle_and_line_rasterizer
// Draws lines, triangle outlines and flat-filled triangles into a colour
// store and reads single pixels back.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole store to zero, one pixel a cycle,
// before it raises ready; configuration writes are taken throughout. Each
// command then runs alone and returns one result item. A read in range
// passes through S_READ and S_READ_DATA. A line takes one slope division on
// the shared serial divider (one quotient bit a cycle) and then one pixel a
// cycle along its major axis. An outline is three lines. A non-flat filled
// triangle takes three divisions, a walk of half its height to pick the
// left edge, then goes row by row: an empty or off-screen row is skipped, a
// drawn row is set up and then its covered pixels are written. The single
// write port of the store (one pixel per cycle) sets the pixel rate.
// ----------------------------------------------------------------------------
module triangle_and_line_rasterizer #(
  parameter int MAX_WIDTH  = tlr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = tlr_pkg::DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = tlr_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  tlr_cmd_if.sink                           cmd,
  tlr_res_if.source                         res,
  input  logic                              cfg_we,
  input  logic [tlr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tlr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = FRAC_BITS + 15;          // fixed-point position width
  localparam int CW    = tlr_pkg::PIX_W;
  localparam int DLW   = tlr_pkg::DELTA_W;
  localparam int CLW   = tlr_pkg::COLOR_W;
  localparam logic [PW:0] ROUND_UP = (PW + 1)'((64'd1 << FRAC_BITS) - 64'd1);

  typedef enum logic [12:0] {
    S_CLEAR      = 13'b0000000000001,
    S_IDLE       = 13'b0000000000010,
    S_READ       = 13'b0000000000100,
    S_READ_DATA  = 13'b0000000001000,
    S_LINE_SETUP = 13'b0000000010000,
    S_LINE_DIV   = 13'b0000000100000,
    S_LINE_WALK  = 13'b0000001000000,
    S_TRI_SORT   = 13'b0000010000000,
    S_TRI_DIV    = 13'b0000100000000,
    S_TRI_MID    = 13'b0001000000000,
    S_TRI_ROW    = 13'b0010000000000,
    S_TRI_SPAN   = 13'b0100000000000,
    S_DONE       = 13'b1000000000000
  } state_t;

  state_t state;

  // configuration
  logic [tlr_pkg::CFG_DATA_W-1:0] scr_w;
  logic [tlr_pkg::CFG_DATA_W-1:0] scr_h;
  logic signed [CW-1:0]           eff_w;
  logic signed [CW-1:0]           eff_h;

  // captured command
  logic [tlr_pkg::KIND_W-1:0] kind;
  logic signed [CW-1:0]       vx [3];
  logic signed [CW-1:0]       vy [3];
  logic [CLW-1:0]             col [3];

  // result
  logic [tlr_pkg::COUNT_W-1:0] count;
  logic [CLW-1:0]              rd_colour;

  // clearing sweep
  logic [AW-1:0] clr_addr;

  // line walk
  logic [1:0]           seg;
  logic                 shallow;
  logic signed [CW-1:0] major;
  logic signed [CW-1:0] steps;
  logic signed [CW-1:0] k;
  logic signed [PW-1:0] pos;
  logic signed [PW-1:0] slope;
  logic signed [DLW-1:0] line_num;
  logic signed [DLW-1:0] line_den;

  // triangle fill
  logic signed [CW-1:0] tx [3];
  logic signed [CW-1:0] ty [3];
  logic signed [CW-1:0] rows;
  logic signed [CW-1:0] upper;
  logic signed [CW-1:0] mid;
  logic signed [CW-1:0] r;
  logic signed [CW-1:0] ycur;
  logic signed [PW-1:0] sl_long;
  logic signed [PW-1:0] sl_01;
  logic signed [PW-1:0] sl_12;
  logic signed [PW-1:0] lp;
  logic signed [PW-1:0] sp;
  logic                 long_left;
  logic signed [CW-1:0] xcur;
  logic signed [CW-1:0] xend;
  logic [1:0]           div_sel;

  // shared divider
  logic                  div_run;
  logic                  div_start;
  logic                  div_done;
  logic signed [PW-1:0]  div_quot;
  logic signed [DLW-1:0] div_num;
  logic signed [DLW-1:0] div_den;

  // store ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [CLW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [CLW-1:0] ram_rdata;

  // ---------------------------------------------------------------- config
  always_comb begin
    eff_w = (32'(scr_w) < MAX_WIDTH)  ? CW'(scr_w) : CW'(MAX_WIDTH);
    eff_h = (32'(scr_h) < MAX_HEIGHT) ? CW'(scr_h) : CW'(MAX_HEIGHT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scr_w <= tlr_pkg::SCREEN_RESET;
      scr_h <= tlr_pkg::SCREEN_RESET;
    end else if (cfg_we) begin
      if (cfg_index == tlr_pkg::CFG_SCREEN_WIDTH) begin
        scr_w <= cfg_data;
      end else if (cfg_index == tlr_pkg::CFG_SCREEN_HEIGHT) begin
        scr_h <= cfg_data;
      end
    end
  end

  // -------------------------------------------------------- line segment
  // Outline edges: v0->v1, v1->v2, v2->v0, each in the colour of its start.
  logic signed [CW-1:0] ax, ay, bx, by;
  logic [CLW-1:0]       seg_col;
  logic                 seg_last;
  logic signed [CW-1:0] ldx, ldy, adx, ady;
  logic signed [CW-1:0] lx0, ly0, lx1, ly1;
  logic                 line_shallow;

  always_comb begin
    case (seg)
      2'd0: begin
        ax = vx[0]; ay = vy[0]; bx = vx[1]; by = vy[1]; seg_col = col[0];
      end
      2'd1: begin
        ax = vx[1]; ay = vy[1]; bx = vx[2]; by = vy[2]; seg_col = col[1];
      end
      default: begin
        ax = vx[2]; ay = vy[2]; bx = vx[0]; by = vy[0]; seg_col = col[2];
      end
    endcase
    seg_last     = (kind == tlr_pkg::KIND_LINE) || (seg == 2'd2);
    ldx          = bx - ax;
    ldy          = by - ay;
    adx          = ldx[CW-1] ? -ldx : ldx;
    ady          = ldy[CW-1] ? -ldy : ldy;
    line_shallow = adx > ady;
    // order by x for shallow lines, by y for steep ones
    if ((line_shallow && ax > bx) || (!line_shallow && ay > by)) begin
      lx0 = bx; ly0 = by; lx1 = ax; ly1 = ay;
    end else begin
      lx0 = ax; ly0 = ay; lx1 = bx; ly1 = by;
    end
  end

  // ------------------------------------------------------ triangle sort
  logic signed [CW-1:0] sx [3];
  logic signed [CW-1:0] sy [3];
  logic signed [CW-1:0] tmp;
  logic signed [CW-1:0] sort_rows;

  always_comb begin
    tmp = '0;
    for (int i = 0; i < 3; i++) begin
      sx[i] = vx[i];
      sy[i] = vy[i];
    end
    if (sy[1] < sy[0]) begin
      tmp = sx[0]; sx[0] = sx[1]; sx[1] = tmp;
      tmp = sy[0]; sy[0] = sy[1]; sy[1] = tmp;
    end
    if (sy[2] < sy[0]) begin
      tmp = sx[0]; sx[0] = sx[2]; sx[2] = tmp;
      tmp = sy[0]; sy[0] = sy[2]; sy[2] = tmp;
    end
    if (sy[2] < sy[1]) begin
      tmp = sx[1]; sx[1] = sx[2]; sx[2] = tmp;
      tmp = sy[1]; sy[1] = sy[2]; sy[2] = tmp;
    end
    sort_rows = sy[2] - sy[0];
  end

  // ------------------------------------------------------- edge stepping
  logic signed [PW-1:0] x0f, x1f;
  logic signed [PW-1:0] sp_init;
  logic signed [PW-1:0] lp_step;
  logic signed [PW-1:0] sp_step;
  logic signed [CW-1:0] r_next;

  always_comb begin
    x0f     = PW'(tx[0]) <<< FRAC_BITS;
    x1f     = PW'(tx[1]) <<< FRAC_BITS;
    sp_init = (upper == '0) ? x1f : x0f;
    r_next  = r + CW'(1);
    lp_step = lp + sl_long;
    if (r_next == upper) begin
      sp_step = x1f;
    end else if (r < upper) begin
      sp_step = sp + sl_01;
    end else begin
      sp_step = sp + sl_12;
    end
  end

  // -------------------------------------------------------- row span
  logic signed [PW-1:0] left_pos, right_pos;
  logic signed [PW:0]   span_diff;
  logic signed [PW:0]   span_ceil;
  logic signed [CW-1:0] span_fl;
  logic signed [CW-1:0] span_end;
  logic signed [CW-1:0] span_xs;
  logic signed [CW-1:0] span_xe;

  always_comb begin
    left_pos  = long_left ? lp : sp;
    right_pos = long_left ? sp : lp;
    span_diff = (PW + 1)'(right_pos) - (PW + 1)'(left_pos);
    span_ceil = (span_diff + ROUND_UP) >>> FRAC_BITS;
    span_fl   = CW'(left_pos >>> FRAC_BITS);
    span_end  = span_fl + CW'(span_ceil);
    span_xs   = span_fl[CW-1] ? '0 : span_fl;
    span_xe   = (span_end > eff_w) ? eff_w : span_end;
  end

  // ----------------------------------------------------------- plotting
  logic signed [CW-1:0] px, py;
  logic                 plot_req;
  logic                 plot_fire;
  logic [CLW-1:0]       plot_col;
  logic [CW-2:0]        pxu, pyu;
  logic [AW-1:0]        plot_addr;

  always_comb begin
    if (state == S_TRI_SPAN) begin
      px       = xcur;
      py       = ycur;
      plot_req = xcur < xend;
      plot_col = col[0];
    end else begin
      px       = shallow ? major : CW'(pos >>> FRAC_BITS);
      py       = shallow ? CW'(pos >>> FRAC_BITS) : major;
      plot_req = (state == S_LINE_WALK) && (k != steps);
      plot_col = seg_col;
    end
    plot_fire = plot_req && !px[CW-1] && !py[CW-1] && (px < eff_w) && (py < eff_h);
    pxu       = px[CW-2:0];
    pyu       = py[CW-2:0];
    plot_addr = AW'(AW'(pyu) * AW'(MAX_WIDTH) + AW'(pxu));
  end

  // ------------------------------------------------------ divider feed
  always_comb begin
    case (div_sel)
      2'd0: begin
        div_num = DLW'(tx[2] - tx[0]); div_den = DLW'(ty[2] - ty[0]);
      end
      2'd1: begin
        div_num = DLW'(tx[1] - tx[0]); div_den = DLW'(ty[1] - ty[0]);
      end
      default: begin
        div_num = DLW'(tx[2] - tx[1]); div_den = DLW'(ty[2] - ty[1]);
      end
    endcase
    if (state == S_LINE_DIV) begin
      div_num = line_num;
      div_den = line_den;
    end
    div_start = ((state == S_LINE_DIV) || (state == S_TRI_DIV)) && !div_run;
  end

  tlr_div #(
    .FRAC_BITS (FRAC_BITS),
    .POS_W     (PW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // ------------------------------------------------------------- store
  logic read_in_range;

  always_comb begin
    ram_we    = (state == S_CLEAR) || plot_fire;
    ram_waddr = (state == S_CLEAR) ? clr_addr : plot_addr;
    ram_wdata = (state == S_CLEAR) ? '0 : plot_col;
    ram_raddr = AW'(AW'(vy[0][CW-2:0]) * AW'(MAX_WIDTH) + AW'(vx[0][CW-2:0]));
    read_in_range = (cmd.first_x >= 0) && (cmd.first_y >= 0) &&
                    (CW'(cmd.first_x) < eff_w) && (CW'(cmd.first_y) < eff_h);
  end

  tlr_ram #(
    .WIDTH (CLW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ------------------------------------------------------------ handshake
  assign cmd.ready          = (state == S_IDLE);
  assign res.valid          = (state == S_DONE);
  assign res.read_colour    = rd_colour;
  assign res.pixels_written = count;

  // ------------------------------------------------------------ sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      div_run  <= 1'b0;
    end else begin
      if (div_start) begin
        div_run <= 1'b1;
      end else if (div_done) begin
        div_run <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd.valid) begin
            case (cmd.kind)
              tlr_pkg::KIND_LINE,
              tlr_pkg::KIND_OUTLINE: state <= S_LINE_SETUP;
              tlr_pkg::KIND_FILL:    state <= S_TRI_SORT;
              default:               state <= read_in_range ? S_READ : S_DONE;
            endcase
          end
        end
        S_READ:      state <= S_READ_DATA;
        S_READ_DATA: state <= S_DONE;
        S_LINE_SETUP: begin
          if (!line_shallow && ady == '0) begin
            // empty steep line: go to the next edge, or finish after the last one
            state <= seg_last ? S_DONE : S_LINE_SETUP;
          end else begin
            state <= S_LINE_DIV;
          end
        end
        S_LINE_DIV: begin
          if (div_done) begin
            state <= S_LINE_WALK;
          end
        end
        S_LINE_WALK: begin
          if (k == steps) begin
            state <= seg_last ? S_DONE : S_LINE_SETUP;
          end
        end
        S_TRI_SORT: begin
          state <= (sort_rows > 0) ? S_TRI_DIV : S_DONE;
        end
        S_TRI_DIV: begin
          if (div_done && div_sel == 2'd2) begin
            state <= S_TRI_MID;
          end
        end
        S_TRI_MID: begin
          if (r == mid) begin
            state <= S_TRI_ROW;
          end
        end
        S_TRI_ROW: begin
          if (r == rows || ycur >= eff_h) begin
            state <= S_DONE;
          end else if (!ycur[CW-1] && right_pos > left_pos) begin
            state <= S_TRI_SPAN;
          end
        end
        S_TRI_SPAN: begin
          if (xcur >= xend) begin
            state <= S_TRI_ROW;
          end
        end
        S_DONE: begin
          if (res.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // --------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (plot_fire && count != tlr_pkg::COUNT_MAX) begin
      count <= count + tlr_pkg::COUNT_W'(1);
    end
    case (state)
      S_IDLE: begin
        // capture the item
        kind      <= cmd.kind;
        vx[0]     <= CW'(cmd.first_x);
        vy[0]     <= CW'(cmd.first_y);
        vx[1]     <= CW'(cmd.second_x);
        vy[1]     <= CW'(cmd.second_y);
        vx[2]     <= CW'(cmd.third_x);
        vy[2]     <= CW'(cmd.third_y);
        col[0]    <= cmd.first_colour;
        col[1]    <= cmd.second_colour;
        col[2]    <= cmd.third_colour;
        count     <= '0;
        rd_colour <= '0;
        seg       <= 2'd0;
        div_sel   <= 2'd0;
      end
      S_READ_DATA: begin
        rd_colour <= ram_rdata;
      end
      S_LINE_SETUP: begin
        shallow  <= line_shallow;
        major    <= line_shallow ? lx0 : ly0;
        pos      <= PW'(line_shallow ? ly0 : lx0) <<< FRAC_BITS;
        steps    <= line_shallow ? adx : ady;
        k        <= '0;
        line_num <= DLW'(line_shallow ? (ly1 - ly0) : (lx1 - lx0));
        line_den <= DLW'(line_shallow ? adx : ady);
        if (!line_shallow && ady == '0) begin
          seg <= seg + 2'd1;
        end
      end
      S_LINE_DIV: begin
        if (div_done) begin
          slope <= div_quot;
        end
      end
      S_LINE_WALK: begin
        if (k == steps) begin
          seg <= seg + 2'd1;
        end else begin
          k     <= k + CW'(1);
          major <= major + CW'(1);
          pos   <= pos + slope;
        end
      end
      S_TRI_SORT: begin
        for (int i = 0; i < 3; i++) begin
          tx[i] <= sx[i];
          ty[i] <= sy[i];
        end
        rows  <= sort_rows;
        mid   <= sort_rows >>> 1;
        upper <= sy[1] - sy[0];
      end
      S_TRI_DIV: begin
        if (div_done) begin
          div_sel <= div_sel + 2'd1;
          case (div_sel)
            2'd0:    sl_long <= div_quot;
            2'd1:    sl_01   <= div_quot;
            default: sl_12   <= div_quot;
          endcase
          // start both edges at the top row
          lp   <= x0f;
          sp   <= sp_init;
          r    <= '0;
          ycur <= ty[0];
        end
      end
      S_TRI_MID: begin
        if (r == mid) begin
          long_left <= lp < sp;
          lp        <= x0f;
          sp        <= sp_init;
          r         <= '0;
          ycur      <= ty[0];
        end else begin
          lp <= lp_step;
          sp <= sp_step;
          r  <= r_next;
        end
      end
      S_TRI_ROW: begin
        if (r != rows && ycur < eff_h) begin
          if (!ycur[CW-1] && right_pos > left_pos) begin
            xcur <= span_xs;
            xend <= span_xe;
          end else begin
            // row off screen or empty: advance
            lp   <= lp_step;
            sp   <= sp_step;
            r    <= r_next;
            ycur <= ycur + CW'(1);
          end
        end
      end
      S_TRI_SPAN: begin
        if (xcur >= xend) begin
          lp   <= lp_step;
          sp   <= sp_step;
          r    <= r_next;
          ycur <= ycur + CW'(1);
        end else begin
          xcur <= xcur + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/tlr_checker.sv =====
// ----------------------------------------------------------------------------
// tlr_checker
// Port-level checks of the rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module tlr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cmd_valid,
  input logic                          cmd_ready,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [tlr_pkg::COLOR_W-1:0]   read_colour,
  input logic [tlr_pkg::COUNT_W-1:0]   pixels_written
);

  // one item in flight: no new command while a result waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(cmd_ready && res_valid))
    else $error("ready while a result is pending");

  // busy after every accepted command
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("ready right after accept");

  // a result never carries both a pixel count and a read colour
  a_read_or_draw: assert property (@(posedge clk) disable iff (rst)
    res_valid && pixels_written != '0 |-> read_colour == '0)
    else $error("result mixes read colour and pixel count");

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(read_colour) &&
                                $stable(pixels_written))
    else $error("stalled result changed");

endmodule

bind triangle_and_line_rasterizer tlr_checker u_tlr_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .read_colour    (res.read_colour),
  .pixels_written (res.pixels_written)
);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the triangle and line rasterizer. A queue of draw
// and read commands feeds a clocked driver; a clocked monitor checks every
// result against an in-bench model of the colour store. Both sides idle at
// random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;

  localparam int  STORE_W = tlr_pkg::DEF_MAX_WIDTH;
  localparam int  STORE_H = tlr_pkg::DEF_MAX_HEIGHT;
  localparam longint ONE  = longint'(1) << tlr_pkg::DEF_FRAC_BITS;

  typedef struct {
    tlr_pkg::kind_t                     kind;
    logic signed [tlr_pkg::COORD_W-1:0] ax, ay, bx, by, cx, cy;
    logic [tlr_pkg::COLOR_W-1:0]        ca, cb, cc;
  } draw_cmd_t;

  typedef struct {
    logic [tlr_pkg::COLOR_W-1:0] colour;
    logic [tlr_pkg::COUNT_W-1:0] written;
  } draw_res_t;

  logic clk;
  logic rst;
  logic                           cfg_we;
  logic [tlr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tlr_pkg::CFG_DATA_W-1:0] cfg_data;

  tlr_cmd_if cmd ();
  tlr_res_if res ();

  triangle_and_line_rasterizer uut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Mirror of the colour store and of the screen registers.
  logic [tlr_pkg::COLOR_W-1:0] shadow_store [STORE_W*STORE_H];
  int unsigned                 shadow_w;
  int unsigned                 shadow_h;

  draw_cmd_t pending_cmds[$];
  draw_res_t expected_results[$];

  int unsigned errors;
  int unsigned cmds_sent;
  int unsigned results_checked;
  int unsigned cycle_count;
  int unsigned hold_left;
  bit          hold_done;

  // -------------------------------------------------------------------------
  // Rasterizer model
  // -------------------------------------------------------------------------
  function automatic longint width_in_use();
    return (shadow_w < STORE_W) ? shadow_w : STORE_W;
  endfunction

  function automatic longint height_in_use();
    return (shadow_h < STORE_H) ? shadow_h : STORE_H;
  endfunction

  // Q16 slope, truncated toward zero.
  function automatic longint fx_slope(longint dd, longint di);
    return (dd * ONE) / di;
  endfunction

  // Arithmetic shift floors negative positions too.
  function automatic longint fx_floor(longint v);
    return v >>> tlr_pkg::DEF_FRAC_BITS;
  endfunction

  task automatic put_pixel(longint x, longint y, logic [tlr_pkg::COLOR_W-1:0] col,
                           inout int unsigned cnt);
    if (x < 0 || y < 0 || x >= width_in_use() || y >= height_in_use())
      return;
    shadow_store[y * STORE_W + x] = col;
    cnt++;
  endtask

  task automatic walk_line(longint x0, longint y0, longint x1, longint y1,
                           logic [tlr_pkg::COLOR_W-1:0] col, inout int unsigned cnt);
    longint dx, dy, t, n, slope;
    dx = x1 - x0;
    dy = y1 - y0;
    if ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy)) begin
      // shallow: order by x, end pixel excluded
      if (x0 > x1) begin
        t = x0; x0 = x1; x1 = t;
        t = y0; y0 = y1; y1 = t;
      end
      n = x1 - x0;
      slope = fx_slope(y1 - y0, n);
      for (longint k = 0; k < n; k++)
        put_pixel(x0 + k, fx_floor(y0 * ONE + k * slope), col, cnt);
    end else begin
      // steep: order by y; a point draws nothing
      if (y0 > y1) begin
        t = x0; x0 = x1; x1 = t;
        t = y0; y0 = y1; y1 = t;
      end
      n = y1 - y0;
      if (n == 0)
        return;
      slope = fx_slope(x1 - x0, n);
      for (longint k = 0; k < n; k++)
        put_pixel(fx_floor(x0 * ONE + k * slope), y0 + k, col, cnt);
    end
  endtask

  function automatic longint short_edge_pos(longint x0, longint y0, longint x1,
                                            longint y1, longint x2, longint y2,
                                            longint r);
    longint upper;
    upper = y1 - y0;
    if (r < upper)
      return x0 * ONE + r * fx_slope(x1 - x0, upper);
    return x1 * ONE + (r - upper) * fx_slope(x2 - x1, y2 - y1);
  endfunction

  task automatic fill_tri(longint x0, longint y0, longint x1, longint y1,
                          longint x2, longint y2, logic [tlr_pkg::COLOR_W-1:0] col,
                          inout int unsigned cnt);
    longint t, n, slope_long, lm, sm, rs, re, lp, sp, lft, rgt, fl, span, xs, xe;
    bit     long_left;
    // sort by y with the same three swaps as the block
    if (y1 < y0) begin t = x1; x1 = x0; x0 = t; t = y1; y1 = y0; y0 = t; end
    if (y2 < y0) begin t = x2; x2 = x0; x0 = t; t = y2; y2 = y0; y0 = t; end
    if (y2 < y1) begin t = x2; x2 = x1; x1 = t; t = y2; y2 = y1; y1 = t; end
    n = y2 - y0;
    if (n <= 0)
      return;
    slope_long = fx_slope(x2 - x0, n);
    lm = x0 * ONE + (n / 2) * slope_long;
    sm = short_edge_pos(x0, y0, x1, y1, x2, y2, n / 2);
    long_left = lm < sm;
    rs = (y0 < 0) ? -y0 : 0;
    re = height_in_use() - y0;
    if (re > n)
      re = n;
    for (longint r = rs; r < re; r++) begin
      lp  = x0 * ONE + r * slope_long;
      sp  = short_edge_pos(x0, y0, x1, y1, x2, y2, r);
      lft = long_left ? lp : sp;
      rgt = long_left ? sp : lp;
      if (rgt > lft) begin
        fl   = fx_floor(lft);
        span = (rgt - lft + ONE - 1) / ONE;
        xs   = (fl < 0) ? 0 : fl;
        xe   = fl + span;
        if (xe > width_in_use())
          xe = width_in_use();
        for (longint x = xs; x < xe; x++)
          put_pixel(x, y0 + r, col, cnt);
      end
    end
  endtask

  task automatic raster_predict(input draw_cmd_t c, output draw_res_t r);
    int unsigned cnt;
    cnt = 0;
    r.colour = '0;
    case (c.kind)
      tlr_pkg::KIND_LINE: begin
        walk_line(c.ax, c.ay, c.bx, c.by, c.ca, cnt);
      end
      tlr_pkg::KIND_OUTLINE: begin
        walk_line(c.ax, c.ay, c.bx, c.by, c.ca, cnt);
        walk_line(c.bx, c.by, c.cx, c.cy, c.cb, cnt);
        walk_line(c.cx, c.cy, c.ax, c.ay, c.cc, cnt);
      end
      tlr_pkg::KIND_FILL: begin
        fill_tri(c.ax, c.ay, c.bx, c.by, c.cx, c.cy, c.ca, cnt);
      end
      default: begin
        if (c.ax >= 0 && c.ay >= 0 && c.ax < width_in_use() && c.ay < height_in_use())
          r.colour = shadow_store[longint'(c.ay) * STORE_W + longint'(c.ax)];
      end
    endcase
    r.written = (cnt > tlr_pkg::COUNT_MAX) ? tlr_pkg::COUNT_MAX
                                           : cnt[tlr_pkg::COUNT_W-1:0];
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch at %0t: %s got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // -------------------------------------------------------------------------
  // Clock, cycle count, idle pattern
  // -------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk)
    cycle_count <= cycle_count + 1;

  // Idle with a 38 percent chance on each call, except in a calm window with no idling.
  function automatic bit idle_now();
    if (cycle_count >= 30000 && cycle_count < 70000)
      return 1'b0;
    return $urandom_range(99) < 38;
  endfunction

  // -------------------------------------------------------------------------
  // Driver: hold the item until it is taken, predict on acceptance
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    draw_res_t want;
    if (rst) begin
      cmd.valid <= 1'b0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        raster_predict(pending_cmds[0], want);
        expected_results.push_back(want);
        void'(pending_cmds.pop_front());
        cmds_sent++;
      end
      // a stalled item stays up; otherwise offer the next one or idle
      if (!(cmd.valid && !cmd.ready)) begin
        if (pending_cmds.size() > 0 && !idle_now()) begin
          cmd.valid         <= 1'b1;
          cmd.kind          <= pending_cmds[0].kind;
          cmd.first_x       <= pending_cmds[0].ax;
          cmd.first_y       <= pending_cmds[0].ay;
          cmd.second_x      <= pending_cmds[0].bx;
          cmd.second_y      <= pending_cmds[0].by;
          cmd.third_x       <= pending_cmds[0].cx;
          cmd.third_y       <= pending_cmds[0].cy;
          cmd.first_colour  <= pending_cmds[0].ca;
          cmd.second_colour <= pending_cmds[0].cb;
          cmd.third_colour  <= pending_cmds[0].cc;
        end else begin
          cmd.valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off on the result side, once, while commands keep coming.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && cmds_sent >= 60) begin
      hold_left <= 3000;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: check each taken result against the oldest expectation
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    draw_res_t want;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, pixels_written", res.pixels_written, 0);
        end else begin
          want = expected_results.pop_front();
          if (res.read_colour !== want.colour)
            report_mismatch("read_colour", res.read_colour, want.colour);
          if (res.pixels_written !== want.written)
            report_mismatch("pixels_written", res.pixels_written, want.written);
          results_checked++;
        end
      end
      res.ready <= (hold_left == 0) && !idle_now();
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  function automatic draw_cmd_t make_cmd(tlr_pkg::kind_t k, int ax, int ay, int bx,
                                         int by, int cx, int cy, logic [31:0] ca,
                                         logic [31:0] cb, logic [31:0] cc);
    draw_cmd_t c;
    c.kind = k;
    c.ax = ax[tlr_pkg::COORD_W-1:0]; c.ay = ay[tlr_pkg::COORD_W-1:0];
    c.bx = bx[tlr_pkg::COORD_W-1:0]; c.by = by[tlr_pkg::COORD_W-1:0];
    c.cx = cx[tlr_pkg::COORD_W-1:0]; c.cy = cy[tlr_pkg::COORD_W-1:0];
    c.ca = ca; c.cb = cb; c.cc = cc;
    return c;
  endfunction

  // Mostly near the screen, sometimes anywhere in the 12-bit range.
  function automatic int pick_coord();
    if ($urandom_range(99) < 8)
      return $urandom_range(4095) - 2048;
    return $urandom_range(150) - 12;
  endfunction

  function automatic draw_cmd_t random_cmd();
    int             sel;
    tlr_pkg::kind_t k;
    int             ax, ay;
    sel = $urandom_range(99);
    if (sel < 25)
      k = tlr_pkg::KIND_LINE;
    else if (sel < 43)
      k = tlr_pkg::KIND_OUTLINE;
    else if (sel < 70)
      k = tlr_pkg::KIND_FILL;
    else
      k = tlr_pkg::KIND_READ;
    ax = pick_coord();
    ay = pick_coord();
    // keep most shapes small so the run stays short
    if (k != tlr_pkg::KIND_READ && $urandom_range(99) < 70)
      return make_cmd(k, ax, ay, ax + $urandom_range(40) - 20, ay + $urandom_range(40) - 20,
                      ax + $urandom_range(40) - 20, ay + $urandom_range(40) - 20,
                      $urandom, $urandom, $urandom);
    return make_cmd(k, ax, ay, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                    $urandom, $urandom, $urandom);
  endfunction

  task automatic write_screen(logic [7:0] w, logic [7:0] h);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= tlr_pkg::CFG_SCREEN_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= tlr_pkg::CFG_SCREEN_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
    shadow_w = w;
    shadow_h = h;
  endtask

  // Drain everything, then let the block settle before touching registers.
  task automatic wait_idle();
    while (pending_cmds.size() > 0 || expected_results.size() > 0)
      @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  logic [7:0] phase_w [6] = '{8'd128, 8'd255, 8'd1, 8'd0, 8'd64, 8'd37};
  logic [7:0] phase_h [6] = '{8'd128, 8'd200, 8'd1, 8'd37, 8'd100, 8'd128};

  initial begin
    foreach (shadow_store[i])
      shadow_store[i] = '0;
    shadow_w  = tlr_pkg::SCREEN_RESET;
    shadow_h  = tlr_pkg::SCREEN_RESET;
    errors    = 0;
    cmds_sent = 0;
    results_checked = 0;
    cycle_count = 0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cmd.valid = 1'b0;
    cmd.kind  = '0;
    cmd.first_x  = '0; cmd.first_y  = '0;
    cmd.second_x = '0; cmd.second_y = '0;
    cmd.third_x  = '0; cmd.third_y  = '0;
    cmd.first_colour = '0; cmd.second_colour = '0; cmd.third_colour = '0;
    res.ready = 1'b0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset screen size.
    pending_cmds.push_back(make_cmd(tlr_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(tlr_pkg::KIND_LINE, 2, 3, 40, 3, 0, 0,
                                    32'hFFFF_FFFF, 0, 0));
    pending_cmds.push_back(make_cmd(tlr_pkg::KIND_LINE, 5, 50, 5, 10, 0, 0,
                                    32'h1234_5678, 0, 0));
    pending_cmds.push_back(make_cmd(tlr_pkg::KIND_LINE, 60, 20, 10, 31, 0, 0,
                                    32'hA5A5_5A5A, 0, 0));
    pending_cmds.push_back(make_cmd(tlr_pkg::KIND_LINE, 30, 90, 20, 40, 0, 0,
                                    32'h0F0F_F0F0, 0, 0));
    pending_cmds.push_back(make_cmd(tlr_pkg::KIND_LINE, 9, 9, 9, 9, 0, 0,
                                    32'hDEAD_BEEF, 0, 0));
    pending_cmds.push_back(make_cmd(tlr_pkg::KIND_LINE, 0, 0, 127, 127, 0, 0,
                                    32'h8000_0001, 0, 0));
    pending_cmds.push_back(make_cmd(tlr_pkg::KIND_LINE, -2048, -2048, 2047, 2047, 0, 0,
                                    32'h7FFF_FFFE, 0, 0));
    pending_cmds.push_back(make_cmd(tlr_pkg::KIND_LINE, -5, 70, 200, 60, 0, 0,
                                    32'h0000_0001, 0, 0));
    pending_cmds.push_back(make_cmd(tlr_pkg::KIND_OUTLINE, 10, 10, 60, 20, 30, 70,
                                    32'h1111_1111, 32'h2222_2222, 32'h4444_4444));
    pending_cmds.push_back(make_cmd(tlr_pkg::KIND_OUTLINE, 2047, -2048, -2048, 2047,
                                    100, 100, 32'hFFFF_FFFF, 32'h0, 32'h5555_AAAA));
    pending_cmds.push_back(make_cmd(tlr_pkg::KIND_FILL, 10, 80, 50, 80, 30, 110,
                                    32'hCAFE_0001, 0, 0));
    pending_cmds.push_back(make_cmd(tlr_pkg::KIND_FILL, 30, 40, 10, 70, 50, 70,
                                    32'hCAFE_0002, 0, 0));
    pending_cmds.push_back(make_cmd(tlr_pkg::KIND_FILL, 5, 5, 90, 5, 40, 5,
                                    32'hCAFE_0003, 0, 0));
    pending_cmds.push_back(make_cmd(tlr_pkg::KIND_FILL, 70, 0, 100, 30, 70, 60,
                                    32'hCAFE_0004, 0, 0));
    pending_cmds.push_back(make_cmd(tlr_pkg::KIND_FILL, 70, 0, 40, 30, 70, 60,
                                    32'hCAFE_0005, 0, 0));
    pending_cmds.push_back(make_cmd(tlr_pkg::KIND_FILL, 0, 0, 10, 10, 20, 20,
                                    32'hCAFE_0006, 0, 0));
    pending_cmds.push_back(make_cmd(tlr_pkg::KIND_FILL, 20, -30, -10, 20, 50, 10,
                                    32'hCAFE_0007, 0, 0));
    pending_cmds.push_back(make_cmd(tlr_pkg::KIND_FILL, -2048, -2048, 2047, 0, 0, 2047,
                                    32'hFFFF_FFFF, 0, 0));
    pending_cmds.push_back(make_cmd(tlr_pkg::KIND_READ, 127, 127, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(tlr_pkg::KIND_READ, -1, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(tlr_pkg::KIND_READ, 128, 5, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(tlr_pkg::KIND_READ, 2047, -2048, 0, 0, 0, 0,
                                    0, 0, 0));
    pending_cmds.push_back(make_cmd(tlr_pkg::KIND_READ, 40, 50, 0, 0, 0, 0, 0, 0, 0));
    wait_idle();

    // Random phases over several screen sizes, extremes included.
    for (int p = 0; p < 6; p++) begin
      write_screen(phase_w[p], phase_h[p]);
      repeat (93)
        pending_cmds.push_back(random_cmd());
      wait_idle();
    end

    $display("covered %0d commands, %0d results checked, over 6 screen sizes",
             cmds_sent, results_checked);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Safety net against a hung handshake.
  initial begin
    #100ms;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tlr_pkg.sv
hdl/tlr_cmd_if.sv
hdl/tlr_res_if.sv
hdl/tlr_ram.sv
hdl/tlr_div.sv
hdl/triangle_and_line_rasterizer.sv
hdl/tlr_checker.sv
test/testbench.sv
